// ===== hdl/owm_pkg.sv =====
// Shared types and constants of the one-wire bus master.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package owm_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int TICK_W    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [TICK_W-1:0] RESET_SPACE_TICKS = 8'd2;
    localparam logic [2:0]        LAST_BIT          = 3'd7;

    localparam logic [TICK_W-1:0] RST_RESET_LOW      = 8'd50;
    localparam logic [TICK_W-1:0] RST_PRESENCE_DELAY = 8'd3;
    localparam logic [TICK_W-1:0] RST_RESET_RECOVERY = 8'd45;
    localparam logic [TICK_W-1:0] RST_WRITE_HOLD     = 8'd6;
    localparam logic [TICK_W-1:0] RST_READ_WAIT      = 8'd4;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW      = 3'd0,
        REG_PRESENCE_DELAY = 3'd1,
        REG_RESET_RECOVERY = 3'd2,
        REG_WRITE_HOLD     = 3'd3,
        REG_READ_WAIT      = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_RST_SPACE = 4'd4,
        PH_WR_START  = 4'd5,
        PH_WR_HOLD   = 4'd6,
        PH_WR_REL    = 4'd7,
        PH_RD_START  = 4'd8,
        PH_RD_SAMPLE = 4'd9,
        PH_RD_WAIT   = 4'd10,
        PH_RD_SPACE  = 4'd11
    } phase_t;

    // One tick after classification by the front end.
    typedef struct packed {
        logic        start;   // carries a command with a meaningful opcode
        opcode_t     op;
        logic [7:0]  wbyte;
        logic        line;
    } tick_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] presence_delay;
        logic [TICK_W-1:0] reset_recovery;
        logic [TICK_W-1:0] write_hold;
        logic [TICK_W-1:0] read_wait;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       present;
        logic [7:0] read_byte;
    } result_t;

endpackage

// ===== hdl/owm_front.sv =====
// Front end: takes a tick request from the input stream, classifies it and
// registers it for the tick queue. Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_front import owm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd_valid,
    input  logic [1:0] opcode,
    input  logic [7:0] write_byte,
    input  logic       line_level,
    output logic       out_valid,
    input  logic       out_ready,
    output tick_item_t out_item
);

    logic       valid_reg, valid_next;
    tick_item_t item_reg, item_next;
    opcode_t    op;

    assign op       = opcode_t'(opcode);
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_valid && in_ready) begin
            valid_next      = 1'b1;
            // An opcode without meaning never starts anything.
            item_next.start = cmd_valid && (op != OP_NONE);
            item_next.op    = op;
            item_next.wbyte = write_byte;
            item_next.line  = line_level;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/owm_queue.sv =====
// Two-entry queue of classified ticks between the front end and the sequencer.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_queue import owm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  tick_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output tick_item_t pop_item
);

    tick_item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/owm_back.sv =====
// Back end: the bus sequencer, one queued tick per step, and the result
// register towards the output stream. Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_back import owm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  tick_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        present_reg, present_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    logic        step;

    // Working values after a possible command start on this tick.
    phase_t      ph;
    logic [7:0]  tc;
    logic [2:0]  bi;
    logic [7:0]  sh;
    logic [7:0]  len;
    logic [7:0]  len_min;
    logic [7:0]  tc_inc;
    logic        len_end;
    logic        drive;
    logic        done;

    assign step     = in_valid && (!out_valid_reg || out_ready);
    assign in_ready = !out_valid_reg || out_ready;

    // Start of a command: the tick that carries it is its first timed tick.
    always_comb begin
        ph = phase_reg;
        tc = tick_reg;
        bi = bit_reg;
        sh = shift_reg;
        if (phase_reg == PH_IDLE && in_item.start) begin
            tc = '0;
            bi = '0;
            sh = (in_item.op == OP_WRITE) ? in_item.wbyte : 8'd0;
            unique case (in_item.op)
                OP_RESET: ph = PH_RST_LOW;
                OP_WRITE: ph = PH_WR_START;
                default:  ph = PH_RD_START;
            endcase
        end
    end

    // Length of the timed phase and its end condition; zero counts as one.
    always_comb begin
        unique case (ph)
            PH_RST_LOW:   len = cfg.reset_low;
            PH_RST_WAIT:  len = cfg.presence_delay;
            PH_RST_REC:   len = cfg.reset_recovery;
            PH_RST_SPACE: len = RESET_SPACE_TICKS;
            PH_WR_HOLD:   len = cfg.write_hold;
            PH_RD_WAIT:   len = cfg.read_wait;
            default:      len = 8'd1;
        endcase
        len_min = (len == '0) ? 8'd1 : len;
        tc_inc  = tc + 8'd1;
        len_end = (tc_inc >= len_min);
    end

    // Next state.
    always_comb begin
        phase_next     = ph;
        tick_next      = len_end ? 8'd0 : tc_inc;
        bit_next       = bi;
        shift_next     = sh;
        present_next   = present_reg;
        last_read_next = last_read_reg;
        unique case (ph)
            PH_IDLE: begin
                tick_next = tc;
            end
            PH_RST_LOW: begin
                if (len_end) phase_next = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                if (len_end) phase_next = PH_RST_REC;
            end
            PH_RST_REC: begin
                if (tc == '0) present_next = !in_item.line;
                if (len_end) phase_next = PH_RST_SPACE;
            end
            PH_RST_SPACE: begin
                if (len_end) phase_next = PH_IDLE;
            end
            PH_WR_START: begin
                tick_next  = '0;
                phase_next = PH_WR_HOLD;
            end
            PH_WR_HOLD: begin
                if (len_end) phase_next = PH_WR_REL;
            end
            PH_WR_REL: begin
                shift_next = sh >> 1;
                tick_next  = '0;
                if (bi == LAST_BIT) begin
                    phase_next = PH_IDLE;
                end else begin
                    bit_next   = bi + 3'd1;
                    phase_next = PH_WR_START;
                end
            end
            PH_RD_START: begin
                tick_next  = '0;
                phase_next = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                shift_next = {in_item.line, sh[7:1]};
                tick_next  = '0;
                phase_next = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                if (len_end) begin
                    if (bi == LAST_BIT) begin
                        phase_next = PH_RD_SPACE;
                    end else begin
                        bit_next   = bi + 3'd1;
                        phase_next = PH_RD_START;
                    end
                end
            end
            PH_RD_SPACE: begin
                last_read_next = sh;
                tick_next      = '0;
                phase_next     = PH_IDLE;
            end
            default: begin
                tick_next  = tc;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs of this tick.
    always_comb begin
        drive = 1'b0;
        done  = 1'b0;
        unique case (ph)
            PH_RST_LOW, PH_WR_START, PH_RD_START: drive = 1'b1;
            PH_WR_HOLD:                            drive = !sh[0];
            PH_RST_SPACE:                          done  = len_end;
            PH_WR_REL:                             done  = (bi == LAST_BIT);
            PH_RD_SPACE:                           done  = 1'b1;
            default: begin
                drive = 1'b0;
                done  = 1'b0;
            end
        endcase
        res_next.drive_low = drive;
        res_next.busy      = (ph != PH_IDLE) && (ph <= PH_RD_SPACE);
        res_next.done      = done;
        res_next.present   = present_next;
        res_next.read_byte = last_read_next;
        out_valid_next     = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            present_reg   <= 1'b0;
            last_read_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (step) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                present_reg   <= present_next;
                last_read_reg <= last_read_next;
            end
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // A held result must freeze the sequencer.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> $stable(phase_reg) && $stable(tick_reg))
        else $error("sequencer moved while the result was held");

    // A completing tick always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("command completed but sequencer not idle");

    // The line is only pulled and completion only flagged during a command.
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (res_reg.drive_low || res_reg.done)) |-> res_reg.busy)
        else $error("drive or done outside a command");

endmodule

// ===== hdl/one_wire_bus_master_unit.sv =====
// Top level of the one-wire bus master: configuration registers, front end,
// tick queue and sequencer. Depends on owm_pkg, owm_front, owm_queue, owm_back.
//
//  channel  direction  handshake           payload
//  s_       in         s_tvalid/s_tready   s_tdata, s_tuser (one tick)
//  m_       out        m_tvalid/m_tready   m_tdata (one result per tick)
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Sustained rate is one tick request per clock while results are taken; the
// sequencer advances one step per cycle while a tick is queued and its result
// is not held, and a result is offered once its request has passed the front
// register, the queue entry and the result register in turn. aresetn is synchronous and
// restores the register defaults and an idle bus. A stalled result holds the
// sequencer; the queue and front register keep taking requests until full.
`timescale 1ns / 1ps

module one_wire_bus_master_unit import owm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // write_byte[7:0], line_level[8], zero fill
    input  logic [2:0]           s_tuser,   // cmd_valid[0], opcode[2:1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                            // device_present[3], read_byte[11:4], zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       f_valid, f_ready;
    tick_item_t f_item;
    logic       q_valid, q_ready;
    tick_item_t q_item;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_RESET_LOW:      cfg_next.reset_low      = cfg_data;
                REG_PRESENCE_DELAY: cfg_next.presence_delay = cfg_data;
                REG_RESET_RECOVERY: cfg_next.reset_recovery = cfg_data;
                REG_WRITE_HOLD:     cfg_next.write_hold     = cfg_data;
                REG_READ_WAIT:      cfg_next.read_wait      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low      <= RST_RESET_LOW;
            cfg_reg.presence_delay <= RST_PRESENCE_DELAY;
            cfg_reg.reset_recovery <= RST_RESET_RECOVERY;
            cfg_reg.write_hold     <= RST_WRITE_HOLD;
            cfg_reg.read_wait      <= RST_READ_WAIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    owm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd_valid  (s_tuser[0]),
        .opcode     (s_tuser[2:1]),
        .write_byte (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_item   (f_item)
    );

    owm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    owm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'd0, res.read_byte, res.present, res.done, res.busy, res.drive_low};

endmodule
